@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

@@ sv/p1305_pkg.sv @@
// ----------------------------------------------------------------------------
// Poly1305 package
// Shared types, constants and the command and status structs.
// ----------------------------------------------------------------------------
package p1305_pkg;

	localparam int unsigned LimbW  = 26;
	localparam int unsigned NLimbs = 5;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_R_LOW  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_R_HIGH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_S_LOW  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_S_HIGH = 2'd3;

	localparam logic [63:0] CLAMP_LO = 64'h0ffffffc0fffffff;
	localparam logic [63:0] CLAMP_HI = 64'h0ffffffc0ffffffc;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // absorb the input beat into h
		logic clr_acc;  // zero the product accumulators
		logic mac;      // one multiply-accumulate column step
		logic carry;    // one carry pass over the product
		logic commit;   // write product back as the accumulator
		logic fin;      // final reduction and tag formation
		logic clr_h;    // clear accumulator after tag
		logic [2:0] col;
	} p1305_cmd_t;

	typedef struct packed {
		logic last;
	} p1305_sts_t;

endpackage

@@ sv/p1305_if.sv @@
// ----------------------------------------------------------------------------
// Poly1305 stream interfaces
// Valid/ready channels for the message blocks and for the tags.
// ----------------------------------------------------------------------------
interface p1305_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [4:0]  byte_count;
	logic        last_block;
	modport source (output valid, block_low, block_high, byte_count, last_block, input ready);
	modport sink   (input valid, block_low, block_high, byte_count, last_block, output ready);
endinterface

interface p1305_tag_if;
	logic        valid;
	logic        ready;
	logic [63:0] tag_low;
	logic [63:0] tag_high;
	modport source (output valid, tag_low, tag_high, input ready);
	modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

@@ sv/p1305_ctrl.sv @@
// ----------------------------------------------------------------------------
// Poly1305 controller
// Sequences absorb, the five multiply columns, three carry passes and the tag.
// ----------------------------------------------------------------------------
module p1305_ctrl import p1305_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  p1305_sts_t sts,
	output p1305_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MAC   = 7'b0000010,
		S_CARRY = 7'b0000100,
		S_COMMIT= 7'b0001000,
		S_FIN   = 7'b0010000,
		S_OUT   = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Command decode from the state.
	always_comb begin
		cmd = '0;
		cmd.col = cnt_q;
		unique case (state_q)
			S_IDLE:   begin cmd.load = in_valid; cmd.clr_acc = in_valid; end
			S_MAC:    cmd.mac = 1'b1;
			S_CARRY:  cmd.carry = 1'b1;
			S_COMMIT: cmd.commit = 1'b1;
			S_FIN:    cmd.fin = 1'b1;
			S_OUT:    cmd.clr_h = out_ready;
			S_WAIT:   ;
			default:  ;
		endcase
	end

	// Next state and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_MAC;
					cnt_q   <= '0;
				end
				S_MAC: begin
					if (cnt_q == 3'd4) begin
						state_q <= S_CARRY;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 3'd1;
				end
				S_CARRY: begin
					if (cnt_q == 3'd2) state_q <= S_COMMIT;
					else cnt_q <= cnt_q + 3'd1;
				end
				S_COMMIT: state_q <= sts.last ? S_FIN : S_WAIT;
				S_WAIT:   state_q <= S_IDLE;
				S_FIN:    state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/p1305_dp.sv @@
// ----------------------------------------------------------------------------
// Poly1305 datapath
// Accumulator limbs, one column of five 27x29 products a step, carry and tag.
// ----------------------------------------------------------------------------
module p1305_dp import p1305_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  p1305_cmd_t  cmd,
	output p1305_sts_t  sts,
	input  logic [63:0] r_low,
	input  logic [63:0] r_high,
	input  logic [63:0] s_low,
	input  logic [63:0] s_high,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	input  logic [4:0]  byte_count,
	input  logic        last_block,
	output logic [63:0] tag_low,
	output logic [63:0] tag_high
);

	logic [LimbW-1:0] acc_q [NLimbs];
	logic [LimbW:0]   h_q   [NLimbs];
	logic [63:0]      p_q   [NLimbs];
	logic             last_q;
	logic             empty_q;
	logic [63:0]      tag_lo_q, tag_hi_q;

	logic [63:0]      m_lo, m_hi;
	logic             m_top;
	logic [LimbW-1:0] m   [NLimbs];
	logic [LimbW-1:0] r   [NLimbs];
	logic [63:0]      rl_c, rh_c;

	assign sts.last = last_q;
	assign tag_low  = tag_lo_q;
	assign tag_high = tag_hi_q;

	// Block padding by byte count.
	always_comb begin
		logic [5:0] sh;
		logic [63:0] one;
		m_lo = block_low;
		m_hi = block_high;
		m_top = 1'b0;
		sh = '0;
		one = '0;
		if (byte_count >= 5'd16) begin
			m_top = 1'b1;
		end else if (byte_count >= 5'd9) begin
			sh = {byte_count[2:0], 3'b000};
			one = 64'd1 << sh;
			m_hi = (block_high & (one - 64'd1)) | one;
		end else if (byte_count == 5'd8) begin
			m_hi = 64'd1;
		end else if (byte_count >= 5'd1) begin
			sh = {byte_count[2:0], 3'b000};
			one = 64'd1 << sh;
			m_lo = (block_low & (one - 64'd1)) | one;
			m_hi = '0;
		end else begin
			m_lo = '0;
			m_hi = '0;
		end
	end

	// Limb split of message and clamped r.
	assign rl_c = r_low & CLAMP_LO;
	assign rh_c = r_high & CLAMP_HI;
	always_comb begin
		m[0] = m_lo[25:0];
		m[1] = m_lo[51:26];
		m[2] = {m_hi[13:0], m_lo[63:52]};
		m[3] = m_hi[39:14];
		m[4] = (byte_count == 5'd0) ? '0 : {1'b0, m_top, m_hi[63:40]};
		r[0] = rl_c[25:0];
		r[1] = rl_c[51:26];
		r[2] = {rh_c[13:0], rl_c[63:52]};
		r[3] = rh_c[39:14];
		r[4] = {2'b00, rh_c[63:40]};
	end

	// Column step: limb col of h times each r limb, rotated with the times-5 fold.
	logic [28:0] rr   [NLimbs];
	logic [55:0] prod [NLimbs];
	always_comb begin
		for (int j = 0; j < NLimbs; j++) begin
			int k;
			k = j - int'(cmd.col);
			if (k < 0) begin
				k = k + int'(NLimbs);
				rr[j] = 29'({3'b000, r[k]} * 29'd5);
			end else begin
				rr[j] = {3'b000, r[k]};
			end
			prod[j] = {29'd0, h_q[cmd.col]} * {27'd0, rr[j]};
		end
	end

	// Carry pass with wrap of the top carry times five.
	logic [63:0] pc [NLimbs];
	always_comb begin
		logic [63:0] c;
		c = '0;
		for (int i = 0; i < NLimbs; i++) begin
			logic [63:0] t;
			t = p_q[i] + c;
			c = t >> LimbW;
			pc[i] = {38'd0, t[LimbW-1:0]};
		end
		pc[0] = pc[0] + c * 64'd5;
	end

	// Final reduction: the stored limbs are each below 2^26, so only the check
	// against p remains.
	logic [63:0] f_lo, f_hi, s_sum_lo;
	always_comb begin
		logic [29:0] g [NLimbs];
		logic [LimbW-1:0] hs [NLimbs];
		logic c;
		c = 1'b0;
		for (int i = 0; i < NLimbs; i++) begin
			g[i] = {4'd0, acc_q[i]} + ((i == 0) ? 30'd5 : {29'd0, c});
			c = g[i][LimbW];
		end
		for (int i = 0; i < NLimbs; i++) hs[i] = c ? g[i][LimbW-1:0] : acc_q[i];
		f_lo = {hs[2][11:0], hs[1], hs[0]};
		f_hi = {hs[4][23:0], hs[3], hs[2][25:12]};
		s_sum_lo = f_lo + s_low;
	end

	// Accumulator state. An empty block leaves the accumulator untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLimbs; i++) acc_q[i] <= '0;
			last_q  <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q  <= last_block;
				empty_q <= (byte_count == 5'd0);
			end
			if (cmd.commit && !empty_q)
				for (int i = 0; i < NLimbs; i++) acc_q[i] <= p_q[i][LimbW-1:0];
			if (cmd.clr_h) for (int i = 0; i < NLimbs; i++) acc_q[i] <= '0;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) for (int i = 0; i < NLimbs; i++)
			h_q[i] <= {1'b0, acc_q[i]} + {1'b0, m[i]};
		if (cmd.clr_acc) for (int i = 0; i < NLimbs; i++) p_q[i] <= '0;
		if (cmd.mac) for (int j = 0; j < NLimbs; j++)
			p_q[j] <= p_q[j] + {8'd0, prod[j]};
		if (cmd.carry) for (int i = 0; i < NLimbs; i++) p_q[i] <= pc[i];
		if (cmd.fin) begin
			tag_lo_q <= s_sum_lo;
			tag_hi_q <= f_hi + s_high + {63'd0, s_sum_lo < f_lo};
		end
	end

endmodule

@@ sv/poly1305_mac.sv @@
// ----------------------------------------------------------------------------
// Poly1305 MAC top level
// Configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// From acceptance until the next block can be taken, each 16-byte block runs
// one load, five multiply columns through five shared 27x29 bit
// multipliers, three carry passes, a write-back and one turnaround state.
// A last block goes to the final reduction in place of the turnaround, then
// the tag is offered from its register until taken, so the next block also
// waits for any output stall. A block with a byte count of zero absorbs
// nothing but takes the same time.
// Write keys only while idle; r is clamped internally.
module poly1305_mac import p1305_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [63:0]        cfg_data,
	p1305_blk_if.sink          blk,
	p1305_tag_if.source        tag
);

	logic [63:0] r_low_q, r_high_q, s_low_q, s_high_q;
	p1305_cmd_t  cmd;
	p1305_sts_t  sts;

	// Key register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q <= '0; r_high_q <= '0; s_low_q <= '0; s_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_R_LOW:  r_low_q  <= cfg_data;
				REG_R_HIGH: r_high_q <= cfg_data;
				REG_S_LOW:  s_low_q  <= cfg_data;
				REG_S_HIGH: s_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	p1305_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(blk.valid), .in_ready(blk.ready),
		.out_valid(tag.valid), .out_ready(tag.ready),
		.sts, .cmd
	);

	p1305_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.r_low(r_low_q), .r_high(r_high_q), .s_low(s_low_q), .s_high(s_high_q),
		.block_low(blk.block_low), .block_high(blk.block_high),
		.byte_count(blk.byte_count), .last_block(blk.last_block),
		.tag_low(tag.tag_low), .tag_high(tag.tag_high)
	);

endmodule

@@ sv/p1305_chk.sv @@
// ----------------------------------------------------------------------------
// Poly1305 port checker
// Observes the top-level handshakes and checks block ordering.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module p1305_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready
);
	`CHK_IMPL(a_excl, clk, arst_n, out_valid, !in_ready)
	`CHK_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CHK_NEXT(a_nolast, clk, arst_n, in_valid && in_ready && !in_last, !out_valid)
endmodule

bind poly1305_mac p1305_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(blk.valid), .in_ready(blk.ready), .in_last(blk.last_block),
	.out_valid(tag.valid), .out_ready(tag.ready)
);
